// File: rtl/core/obusp_pkg.sv
// Shared types and constants of the OBU temporal unit splitter.
package obusp_pkg;

   localparam int CMD_DEPTH  = 8;
   localparam int HOLD_CNT_W = 4;

   localparam logic [3:0] OBU_TEMPORAL_DELIMITER = 4'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_SIZE = 2'd1;
   localparam logic [1:0] ST_CORRUPT = 2'd2;

   typedef enum logic [1:0] {
      CMD_DATA,
      CMD_RELEASE,
      CMD_MARKER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [7:0]            data;
      logic                  tu_first;
      logic                  obu_last;
      logic [3:0]            unit_type;
      logic [2:0]            temporal;
      logic [1:0]            spatial;
      logic [HOLD_CNT_W-1:0] count;
      logic                  tu_closed;
      logic [1:0]            status;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

// File: rtl/core/obusp_queue.sv
// Small synchronous FIFO with flop storage and fall-through read.
module obusp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             not_full
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != CNT_W'(DEPTH));

endmodule

// File: rtl/core/obusp_front.sv
// Front end: OBU header, extension and LEB128 size parsing, TU boundary decisions.
module obusp_front #(
   parameter int MAX_SIZE_BYTES = 8,
   parameter int HOLD_DEPTH     = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  logic [7:0]        req_tdata,
   input  logic              cmd_room,
   input  logic              byte_room,
   output logic              cmd_push,
   output obusp_pkg::cmd_type cmd_data,
   output logic              byte_push,
   output logic [7:0]        byte_data
);
   import obusp_pkg::*;

   localparam int SCNT_W = $clog2(MAX_SIZE_BYTES + 1);
   localparam int HCNT_W = $clog2(HOLD_DEPTH + 1);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_EXT     = 2'd1;
   localparam logic [1:0] PH_SIZE    = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [HCNT_W-1:0] held_count_ff, held_count_in;
   logic [3:0]        type_ff, type_in;
   logic              ext_ff, ext_in;
   logic [2:0]        temporal_ff, temporal_in;
   logic [1:0]        spatial_ff, spatial_in;
   logic              has_size_ff, has_size_in;
   logic [31:0]       accum_ff, accum_in;
   logic [SCNT_W-1:0] size_cnt_ff, size_cnt_in;
   logic [31:0]       left_ff, left_in;
   logic              tu_open_ff, tu_open_in;
   logic [1:0]        prev_spatial_ff, prev_spatial_in;
   logic              halted_ff, halted_in;

   logic              accept;
   logic [HCNT_W-1:0] hold_base;
   logic              hold_room;
   logic [HCNT_W-1:0] held_next;
   logic [35:0]       bits_ext;
   logic [35:0]       shifted;
   logic [35:0]       sum;
   logic              overflow;
   logic [SCNT_W-1:0] cnt_next;
   logic              spatial_change;
   logic              new_tu;
   logic [31:0]       left_dec;
   logic              fail;
   logic [1:0]        fail_status;
   logic              do_release;

   assign req_tready = cmd_room && byte_room;
   assign accept     = req_tvalid && req_tready;
   assign byte_data  = req_tdata;

   assign hold_base = (phase_ff == PH_HEADER) ? '0 : held_count_ff;
   assign hold_room = (hold_base < HCNT_W'(HOLD_DEPTH));
   assign held_next = hold_room ? HCNT_W'(hold_base + 1'b1) : hold_base;

   assign bits_ext = {29'b0, req_tdata[6:0]};
   assign left_dec = (left_ff != '0) ? left_ff - 32'd1 : left_ff;

   always_comb begin
      priority if (size_cnt_ff == SCNT_W'(0)) begin
         shifted = bits_ext;
      end else if (size_cnt_ff == SCNT_W'(1)) begin
         shifted = bits_ext << 7;
      end else if (size_cnt_ff == SCNT_W'(2)) begin
         shifted = bits_ext << 14;
      end else if (size_cnt_ff == SCNT_W'(3)) begin
         shifted = bits_ext << 21;
      end else if (size_cnt_ff == SCNT_W'(4)) begin
         shifted = bits_ext << 28;
      end else begin
         shifted = '0;
      end
      if (size_cnt_ff < SCNT_W'(5)) begin
         sum      = {4'b0, accum_ff} + shifted;
         overflow = (sum[35:32] != 4'b0);
      end else begin
         sum      = {4'b0, accum_ff};
         overflow = (req_tdata[6:0] != 7'b0);
      end
      cnt_next       = SCNT_W'(size_cnt_ff + 1'b1);
      spatial_change = ext_ff && (spatial_ff != prev_spatial_ff);
      new_tu         = !tu_open_ff || (type_ff == OBU_TEMPORAL_DELIMITER) ||
                       (sum[31:0] == '0) || spatial_change;
   end

   always_comb begin
      phase_in        = phase_ff;
      held_count_in   = held_count_ff;
      type_in         = type_ff;
      ext_in          = ext_ff;
      temporal_in     = temporal_ff;
      spatial_in      = spatial_ff;
      has_size_in     = has_size_ff;
      accum_in        = accum_ff;
      size_cnt_in     = size_cnt_ff;
      left_in         = left_ff;
      tu_open_in      = tu_open_ff;
      prev_spatial_in = prev_spatial_ff;
      halted_in       = halted_ff;
      cmd_push        = 1'b0;
      cmd_data        = '0;
      byte_push       = 1'b0;
      fail            = 1'b0;
      fail_status     = ST_OK;
      do_release      = 1'b0;

      if (accept && !halted_ff) begin
         if (req_tuser) begin
            if (tu_open_ff) begin
               cmd_push           = 1'b1;
               cmd_data.kind      = CMD_MARKER;
               cmd_data.tu_closed = 1'b1;
               tu_open_in         = 1'b0;
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  byte_push     = hold_room;
                  held_count_in = held_next;
                  type_in       = req_tdata[6:3];
                  ext_in        = req_tdata[2];
                  has_size_in   = req_tdata[1];
                  temporal_in   = '0;
                  spatial_in    = '0;
                  if (req_tdata[2]) begin
                     phase_in = PH_EXT;
                  end else if (!req_tdata[1]) begin
                     fail        = 1'b1;
                     fail_status = ST_NO_SIZE;
                  end else begin
                     phase_in    = PH_SIZE;
                     accum_in    = '0;
                     size_cnt_in = '0;
                  end
               end
               PH_EXT: begin
                  byte_push     = hold_room;
                  held_count_in = held_next;
                  temporal_in   = req_tdata[7:5];
                  spatial_in    = req_tdata[4:3];
                  if (!has_size_ff) begin
                     fail        = 1'b1;
                     fail_status = ST_NO_SIZE;
                  end else begin
                     phase_in    = PH_SIZE;
                     accum_in    = '0;
                     size_cnt_in = '0;
                  end
               end
               PH_SIZE: begin
                  byte_push     = hold_room;
                  held_count_in = held_next;
                  if (overflow) begin
                     fail        = 1'b1;
                     fail_status = ST_CORRUPT;
                  end else begin
                     accum_in    = sum[31:0];
                     size_cnt_in = cnt_next;
                     if (req_tdata[7]) begin
                        if (cnt_next >= SCNT_W'(MAX_SIZE_BYTES)) begin
                           fail        = 1'b1;
                           fail_status = ST_CORRUPT;
                        end
                     end else begin
                        do_release = 1'b1;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  cmd_push          = 1'b1;
                  cmd_data.kind     = CMD_DATA;
                  cmd_data.data     = req_tdata;
                  cmd_data.tu_first = !tu_open_ff;
                  cmd_data.obu_last = (left_dec == '0);
                  cmd_data.unit_type = type_ff;
                  cmd_data.temporal = temporal_ff;
                  cmd_data.spatial  = spatial_ff;
                  tu_open_in        = 1'b1;
                  left_in           = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_HEADER;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end

      if (do_release) begin
         cmd_push           = 1'b1;
         cmd_data.kind      = CMD_RELEASE;
         cmd_data.tu_first  = new_tu;
         cmd_data.obu_last  = (sum[31:0] == '0);
         cmd_data.unit_type = type_ff;
         cmd_data.temporal  = temporal_ff;
         cmd_data.spatial   = spatial_ff;
         cmd_data.count     = HOLD_CNT_W'(held_next);
         if (spatial_change) begin
            prev_spatial_in = spatial_ff;
         end
         tu_open_in    = 1'b1;
         left_in       = sum[31:0];
         phase_in      = (sum[31:0] != '0) ? PH_PAYLOAD : PH_HEADER;
         held_count_in = '0;
         accum_in      = '0;
         size_cnt_in   = '0;
      end

      if (fail) begin
         cmd_push        = 1'b1;
         cmd_data        = '0;
         cmd_data.kind   = CMD_MARKER;
         cmd_data.status = fail_status;
         halted_in       = 1'b1;
         phase_in        = PH_HEADER;
         held_count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         held_count_ff   <= '0;
         type_ff         <= '0;
         ext_ff          <= 1'b0;
         temporal_ff     <= '0;
         spatial_ff      <= '0;
         has_size_ff     <= 1'b0;
         accum_ff        <= '0;
         size_cnt_ff     <= '0;
         left_ff         <= '0;
         tu_open_ff      <= 1'b0;
         prev_spatial_ff <= '0;
         halted_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         held_count_ff   <= held_count_in;
         type_ff         <= type_in;
         ext_ff          <= ext_in;
         temporal_ff     <= temporal_in;
         spatial_ff      <= spatial_in;
         has_size_ff     <= has_size_in;
         accum_ff        <= accum_in;
         size_cnt_ff     <= size_cnt_in;
         left_ff         <= left_in;
         tu_open_ff      <= tu_open_in;
         prev_spatial_ff <= prev_spatial_in;
         halted_ff       <= halted_in;
      end
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= HCNT_W'(HOLD_DEPTH))
      else $error("held byte count beyond hold depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd_push || byte_push) |-> (cmd_room && byte_room))
      else $error("push into a full queue");

endmodule

// File: rtl/core/obusp_back.sv
// Back end: expands queued commands into result beats behind an output register.
module obusp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  obusp_pkg::cmd_type cmd_head,
   output logic               cmd_pop,
   input  logic               byte_valid,
   input  logic [7:0]         byte_head,
   output logic               byte_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);
   import obusp_pkg::*;

   logic [HOLD_CNT_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  is_data_ff, is_data_in;
   logic                  tu_first_ff, tu_first_in;
   logic                  obu_first_ff, obu_first_in;
   logic                  obu_last_ff, obu_last_in;
   logic [3:0]            type_ff, type_in;
   logic [2:0]            temporal_ff, temporal_in;
   logic [1:0]            spatial_ff, spatial_in;
   logic                  closed_ff, closed_in;
   logic [1:0]            status_ff, status_in;
   logic                  last_ff, last_in;

   logic                  load;
   logic                  rel_last;

   assign load     = !valid_ff || rsp_tready;
   assign rel_last = (HOLD_CNT_W'(idx_ff + 1'b1) == cmd_head.count);

   always_comb begin
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      is_data_in   = is_data_ff;
      tu_first_in  = tu_first_ff;
      obu_first_in = obu_first_ff;
      obu_last_in  = obu_last_ff;
      type_in      = type_ff;
      temporal_in  = temporal_ff;
      spatial_in   = spatial_ff;
      closed_in    = closed_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      cmd_pop      = 1'b0;
      byte_pop     = 1'b0;

      if (load) begin
         valid_in = 1'b0;
         if (cmd_valid) begin
            unique case (cmd_head.kind)
               CMD_DATA: begin
                  cmd_pop      = 1'b1;
                  valid_in     = 1'b1;
                  byte_in      = cmd_head.data;
                  is_data_in   = 1'b1;
                  tu_first_in  = cmd_head.tu_first;
                  obu_first_in = 1'b0;
                  obu_last_in  = cmd_head.obu_last;
                  type_in      = cmd_head.unit_type;
                  temporal_in  = cmd_head.temporal;
                  spatial_in   = cmd_head.spatial;
                  closed_in    = 1'b0;
                  status_in    = ST_OK;
                  last_in      = 1'b1;
               end
               CMD_RELEASE: begin
                  if (byte_valid) begin
                     byte_pop     = 1'b1;
                     cmd_pop      = rel_last;
                     idx_in       = rel_last ? '0 : HOLD_CNT_W'(idx_ff + 1'b1);
                     valid_in     = 1'b1;
                     byte_in      = byte_head;
                     is_data_in   = 1'b1;
                     tu_first_in  = (idx_ff == '0) && cmd_head.tu_first;
                     obu_first_in = (idx_ff == '0);
                     obu_last_in  = rel_last && cmd_head.obu_last;
                     type_in      = cmd_head.unit_type;
                     temporal_in  = cmd_head.temporal;
                     spatial_in   = cmd_head.spatial;
                     closed_in    = 1'b0;
                     status_in    = ST_OK;
                     last_in      = rel_last;
                  end
               end
               CMD_MARKER: begin
                  cmd_pop      = 1'b1;
                  valid_in     = 1'b1;
                  byte_in      = '0;
                  is_data_in   = 1'b0;
                  tu_first_in  = 1'b0;
                  obu_first_in = 1'b0;
                  obu_last_in  = 1'b0;
                  type_in      = '0;
                  temporal_in  = '0;
                  spatial_in   = '0;
                  closed_in    = cmd_head.tu_closed;
                  status_in    = cmd_head.status;
                  last_in      = 1'b1;
               end
               default: begin
                  cmd_pop = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      is_data_ff   <= is_data_in;
      tu_first_ff  <= tu_first_in;
      obu_first_ff <= obu_first_in;
      obu_last_ff  <= obu_last_in;
      type_ff      <= type_in;
      temporal_ff  <= temporal_in;
      spatial_ff   <= spatial_in;
      closed_ff    <= closed_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = is_data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {1'b0, status_ff, closed_ff, spatial_ff, temporal_ff, type_ff,
                        obu_last_ff, obu_first_ff, tu_first_ff, byte_ff};

   a_release_bytes: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_head.kind == CMD_RELEASE) |-> byte_valid)
      else $error("release command without held bytes");

   a_release_index: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_head.kind == CMD_RELEASE) |-> (idx_ff < cmd_head.count))
      else $error("release index past byte count");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && is_data_ff) |-> (status_ff == ST_OK && !closed_ff))
      else $error("data beat carries marker fields");

endmodule

// File: rtl/core/obu_stream_temporal_unit_splitter.sv
// Top level of the AV1 OBU stream temporal unit splitter.
//
// Input channel req_*: one beat per stream byte (req_tuser = 0) or an
// end-of-stream drain (req_tuser = 1). Output channel rsp_*: one beat per
// result; rsp_tlast marks the last beat caused by one input beat.
// Header, extension and size bytes are held until the LEB128 size ends,
// then come out in one burst, one beat per cycle while rsp_tready stays
// high, the first tagged obu_first. Payload bytes pass through one per cycle
// on the same terms, by way of the command queue and the output register;
// the command queue (8 entries) and the held byte queue soak up the input
// while the burst drains.
// Errors (no size field, corrupt size) give one status beat and halt the
// block until reset; later beats are taken and dropped.
// Reset clears parse state, queues and the output valid flag.
// A stalled receiver (rsp_tready low) holds the output beat; input is taken
// until a queue fills, then req_tready drops.
module obu_stream_temporal_unit_splitter #(
   parameter int MAX_SIZE_BYTES = 8,
   parameter int HOLD_DEPTH     = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [8] tu_first, [9] obu_first,
                                    // [10] obu_last, [14:11] unit_type,
                                    // [17:15] layer_temporal, [19:18] layer_spatial,
                                    // [20] tu_closed, [22:21] status, [23] zero
   output logic        rsp_tuser,   // [0] is_data
   output logic        rsp_tlast    // burst_last
);
   import obusp_pkg::*;

   localparam int BYTE_DEPTH = 2 ** $clog2(2 * HOLD_DEPTH);

   cmd_type          cmd_wdata;
   cmd_type          cmd_head;
   logic [CMD_W-1:0] cmd_rvec;
   logic             cmd_push;
   logic             cmd_pop;
   logic             cmd_valid;
   logic             cmd_room;

   logic [7:0]       byte_wdata;
   logic [7:0]       byte_head;
   logic             byte_push;
   logic             byte_pop;
   logic             byte_valid;
   logic             byte_room;

   assign cmd_head = cmd_type'(cmd_rvec);

   obusp_front #(
      .MAX_SIZE_BYTES(MAX_SIZE_BYTES),
      .HOLD_DEPTH    (HOLD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd_room  (cmd_room),
      .byte_room (byte_room),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_wdata),
      .byte_push (byte_push),
      .byte_data (byte_wdata)
   );

   obusp_queue #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_wdata),
      .pop      (cmd_pop),
      .pop_data (cmd_rvec),
      .not_empty(cmd_valid),
      .not_full (cmd_room)
   );

   obusp_queue #(
      .WIDTH(8),
      .DEPTH(BYTE_DEPTH)
   ) u_byte_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (byte_push),
      .push_data(byte_wdata),
      .pop      (byte_pop),
      .pop_data (byte_head),
      .not_empty(byte_valid),
      .not_full (byte_room)
   );

   obusp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .byte_valid(byte_valid),
      .byte_head (byte_head),
      .byte_pop  (byte_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
